### hdl/sabm_pkg.sv
// ----------------------------------------------------------------------------
// sabm_pkg
// Shared types and constants of the sized-access byte memory: transfer
// payloads, opcodes, byte-lane geometry and the clear sequencer states.
// ----------------------------------------------------------------------------
package sabm_pkg;

    // Byte lanes per memory row (one bank per lane)
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    // Configuration register
    localparam int          CFG_W         = 17;
    localparam logic [16:0] MEM_SIZE_RST  = 17'h10000;

    // Opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Input transfer payload
    typedef struct packed {
        logic        opcode;
        logic [1:0]  access_size;
        logic        sign_extend;
        logic        big_endian;
        logic [31:0] address;
        logic [63:0] write_data;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [63:0] read_data;
        logic        error;
    } t_out_item;

    // Clear sequencer states
    typedef enum logic {
        CLR_SWEEP,
        CLR_IDLE
    } t_clr_state;

endpackage

### hdl/sabm_ram.sv
// ----------------------------------------------------------------------------
// sabm_ram
// One byte-wide bank: single port, synchronous write, registered read.
// ----------------------------------------------------------------------------
module sabm_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/sabm_clear.sv
// ----------------------------------------------------------------------------
// sabm_clear
// Post-reset sweep: walks every row once, zeroing all banks, then idles.
// ----------------------------------------------------------------------------
module sabm_clear #(
    parameter int ROWS  = 8192,
    parameter int ROW_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_busy,
    output logic [ROW_W-1:0] o_row
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    sabm_pkg::t_clr_state r_state, n_state;
    logic [ROW_W-1:0]     r_row, n_row;

    // State and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sabm_pkg::CLR_SWEEP;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        o_busy  = 1'b0;
        unique case (r_state)
            sabm_pkg::CLR_SWEEP: begin
                o_busy = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = sabm_pkg::CLR_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            sabm_pkg::CLR_IDLE: begin
                o_busy = 1'b0;
            end
            default: begin
                n_state = sabm_pkg::CLR_IDLE;
            end
        endcase
    end

    assign o_row = r_row;

endmodule

### hdl/sized_access_byte_memory_unit.sv
// ----------------------------------------------------------------------------
// sized_access_byte_memory_unit
// Byte-addressable memory serving sized, bounds-checked reads and writes.
// ----------------------------------------------------------------------------
// After reset the unit zeroes its store, sweeping every row once, and holds
// o_in_stall high meanwhile; configuration writes are taken at any time.
// Afterwards it takes one transfer per cycle while the output is not stalled:
// the store is eight byte-wide banks, one per address bit [2:0], each with a
// single port, so any 1/2/4/8-byte access, aligned or not, touches each bank
// at most once. A result is registered in the bank read registers and stage
// 1, then in the output register, which holds it while i_out_stall is high.
// Writes are committed at the accepting edge, so a following read always
// sees them. An access with address + size beyond min(mem_size, MEM_BYTES)
// returns error with zero data and leaves the store unchanged.
// ----------------------------------------------------------------------------
module sized_access_byte_memory_unit #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sabm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sabm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [16:0]         i_cfg_wdata
);

    localparam int ROWS  = (MEM_BYTES + sabm_pkg::LANES - 1) / sabm_pkg::LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

    // Configuration register
    logic [16:0] r_mem_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= sabm_pkg::MEM_SIZE_RST;
        end else if (i_cfg_we) begin
            r_mem_size <= i_cfg_wdata;
        end
    end

    // Clear sweep
    logic             w_clr_busy;
    logic [ROW_W-1:0] w_clr_row;

    sabm_clear #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (w_clr_busy),
        .o_row   (w_clr_row)
    );

    // Handshake
    logic w_s1_adv;
    logic w_in_acc;
    logic r_s1_valid;
    logic r_out_valid;

    assign w_s1_adv   = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_clr_busy || (r_s1_valid && !w_s1_adv);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Request decode and bounds check
    logic [2:0]       w_off;
    logic [ROW_W-1:0] w_base_row;
    logic [3:0]       w_nbytes;
    logic [2:0]       w_nm1;
    logic [32:0]      w_end;
    logic [32:0]      w_usable;
    logic             w_err;
    logic             w_do_write;

    assign w_off      = i_in_item.address[2:0];
    assign w_base_row = i_in_item.address[ROW_W+2:3];
    assign w_nbytes   = 4'd1 << i_in_item.access_size;
    assign w_nm1      = 3'(w_nbytes - 4'd1);
    assign w_end      = {1'b0, i_in_item.address} + 33'(w_nbytes);
    assign w_usable   = (33'(r_mem_size) < MEM_LIM) ? 33'(r_mem_size) : MEM_LIM;
    assign w_err      = w_end > w_usable;
    assign w_do_write = w_in_acc && (i_in_item.opcode == sabm_pkg::OP_WRITE) && !w_err;

    // Per-bank address, write lane selection and memories
    logic [7:0] w_rdata [sabm_pkg::LANES];

    for (genvar b = 0; b < sabm_pkg::LANES; b++) begin : g_bank
        logic [2:0]       w_k;
        logic [2:0]       w_lane;
        logic             w_used;
        logic [ROW_W-1:0] w_row;
        logic             w_we;
        logic [ROW_W-1:0] w_addr;
        logic [7:0]       w_wbyte;

        // byte k of the access lands in this bank
        assign w_k    = 3'(b) - w_off;
        assign w_used = {1'b0, w_k} < w_nbytes;
        assign w_row  = w_base_row + ROW_W'((3'(b) < w_off) ? 1 : 0);
        assign w_lane = i_in_item.big_endian ? (w_nm1 - w_k) : w_k;

        assign w_wbyte = w_clr_busy ? 8'h00
                                    : i_in_item.write_data[{w_lane, 3'b000} +: 8];
        assign w_we    = w_clr_busy || (w_do_write && w_used);
        assign w_addr  = w_clr_busy ? w_clr_row : w_row;

        sabm_ram #(
            .DEPTH  (ROWS),
            .ADDR_W (ROW_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_re    (w_in_acc),
            .i_addr  (w_addr),
            .i_wdata (w_wbyte),
            .o_rdata (w_rdata[b])
        );
    end

    // Stage 1: read in flight
    logic       r_s1_err;
    logic       r_s1_write;
    logic [1:0] r_s1_lg;
    logic       r_s1_sext;
    logic       r_s1_big;
    logic [2:0] r_s1_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_err   <= w_err;
            r_s1_write <= (i_in_item.opcode == sabm_pkg::OP_WRITE);
            r_s1_lg    <= i_in_item.access_size;
            r_s1_sext  <= i_in_item.sign_extend;
            r_s1_big   <= i_in_item.big_endian;
            r_s1_off   <= w_off;
        end
    end

    // Read data assembly: byte order, width and extension
    logic [3:0]  w_s1_n;
    logic [2:0]  w_s1_nm1;
    logic [7:0]  w_vbyte [sabm_pkg::LANES];
    logic        w_sign;
    logic [63:0] w_value;

    assign w_s1_n   = 4'd1 << r_s1_lg;
    assign w_s1_nm1 = 3'(w_s1_n - 4'd1);

    always_comb begin
        for (int j = 0; j < sabm_pkg::LANES; j++) begin
            w_vbyte[j] = w_rdata[3'(r_s1_off + (r_s1_big ? (w_s1_nm1 - 3'(j)) : 3'(j)))];
        end
    end

    assign w_sign = r_s1_sext && w_vbyte[w_s1_nm1][7];

    always_comb begin
        for (int j = 0; j < sabm_pkg::LANES; j++) begin
            if (4'(j) < w_s1_n) begin
                w_value[8*j +: 8] = w_vbyte[j];
            end else begin
                w_value[8*j +: 8] = w_sign ? 8'hFF : 8'h00;
            end
        end
    end

    // Output register
    sabm_pkg::t_out_item r_out_item;
    logic                r_out_is_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out_item.read_data <= (r_s1_err || r_s1_write) ? 64'd0 : w_value;
            r_out_item.error     <= r_s1_err;
            r_out_is_write       <= r_s1_write;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !w_in_acc)
        else $error("transfer accepted during clear sweep");

    a_clear_ends_at_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_clr_busy) |-> ($past(w_clr_row) == ROW_W'(ROWS - 1)))
        else $error("clear sweep ended early");

    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.error) |-> (r_out_item.read_data == 64'd0))
        else $error("refused access returned data");

    a_write_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_is_write) |-> (r_out_item.read_data == 64'd0))
        else $error("write returned data");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_err) |-> !w_do_write)
        else $error("refused access modified the store");

endmodule
